[rtl/core/dht_pkg.sv]
// shared types, constants and helpers for the double hash table core
package dht_pkg;

  localparam int TABLE_SLOTS = 11;
  localparam int STEP_PRIME  = 7;
  localparam int KEY_BITS    = 32;
  localparam int VALUE_BITS  = 32;

  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;
  localparam int LIVE_W   = 4;

  localparam int IDX_W   = $clog2(TABLE_SLOTS);
  localparam int CNT_W   = $clog2(TABLE_SLOTS + 1);
  localparam int MAX_MR  = (TABLE_SLOTS > STEP_PRIME) ? TABLE_SLOTS : STEP_PRIME;
  localparam int RES_W   = $clog2(MAX_MR + 1);
  localparam int NIB_CNT = (KEY_BITS + 3) / 4;
  localparam int PAD_W   = NIB_CNT * 4;
  localparam int NIB_CW  = $clog2(NIB_CNT + 1);

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 2'd0,
    FN_LOOKUP = 2'd1,
    FN_REMOVE = 2'd2
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  localparam logic [1:0] SL_EMPTY = 2'd0;
  localparam logic [1:0] SL_OCC   = 2'd1;
  localparam logic [1:0] SL_DEL   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_STEP,
    S_PROBE,
    S_FIN
  } state_t;

  typedef struct packed {
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [KEY_BITS-1:0]   wkey;
    logic [VALUE_BITS-1:0] wvalue;
    logic                  re;
    logic [IDX_W-1:0]      raddr;
  } mem_req_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } mem_rd_t;

  // one nibble of a running remainder: (16*r + nib) mod m, for r < m
  function automatic logic [RES_W-1:0] mod_step(input logic [RES_W-1:0] r,
                                                input logic [3:0] nib,
                                                input logic [RES_W-1:0] m);
    logic [RES_W+3:0] t;
    logic [RES_W+3:0] d;
    t = {r, nib};
    for (int b = 3; b >= 0; b--) begin
      d = {4'b0000, m} << b;
      if (t >= d) begin
        t = t - d;
      end
    end
    return t[RES_W-1:0];
  endfunction

endpackage

[rtl/core/dht_mem.sv]
// key and value storage, one write port and one registered read port
module dht_mem
  import dht_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output mem_rd_t  rd
);

  mem_rd_t mem [TABLE_SLOTS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= '{key: req.wkey, value: req.wvalue};
    end
    if (req.re) begin
      rd <= mem[req.raddr];
    end
  end

endmodule

[rtl/core/dht_ctrl.sv]
// request sequencer: hashing, probe walk, slot status, count and result register
module dht_ctrl
  import dht_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [FUNC_W-1:0]     func,
  input  logic [KEY_BITS-1:0]   key,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STATUS_W-1:0]   status,
  output logic [31:0]           value_out,
  output logic [SLOT_W-1:0]     slot,
  output logic [LIVE_W-1:0]     live_count,
  output mem_req_t              mem_req,
  input  mem_rd_t               mem_rd
);

  state_t state;
  state_t state_next;

  logic [FUNC_W-1:0]     func_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [PAD_W-1:0]      key_sh;
  logic [NIB_CW-1:0]     nib_cnt;
  logic [RES_W-1:0]      rem_m;
  logic [RES_W-1:0]      rem_r;
  logic [RES_W-1:0]      rem_m_next;
  logic [RES_W-1:0]      rem_r_next;
  logic [RES_W-1:0]      step;
  logic [IDX_W-1:0]      idx;
  logic [IDX_W:0]        idx_sum;
  logic [IDX_W-1:0]      idx_adv;
  logic [CNT_W-1:0]      issue_cnt;
  logic                  issue;

  logic                  eval_valid;
  logic [IDX_W-1:0]      eval_idx;
  logic                  eval_last;
  logic [1:0]            ev_status;
  logic                  ev_empty;
  logic                  ev_hit;
  logic                  probe_end;

  logic                  hit;
  logic [IDX_W-1:0]      hit_idx;
  logic [VALUE_BITS-1:0] hit_val;
  logic                  have_del;
  logic [IDX_W-1:0]      del_idx;
  logic                  have_empty;
  logic [IDX_W-1:0]      empty_idx;

  logic [1:0]            slot_status [TABLE_SLOTS];
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;

  logic                  fin_go;
  logic                  st_we;
  logic [IDX_W-1:0]      st_waddr;
  logic [1:0]            st_wdata;
  status_t               res_status;
  logic [VALUE_BITS-1:0] res_val;
  logic [IDX_W-1:0]      res_slot;

  status_t               out_status;
  logic [VALUE_BITS-1:0] out_val;
  logic [IDX_W-1:0]      out_slot;
  logic [CNT_W-1:0]      out_count;

  assign rem_m_next = mod_step(rem_m, key_sh[PAD_W-1 -: 4], RES_W'(TABLE_SLOTS));
  assign rem_r_next = mod_step(rem_r, key_sh[PAD_W-1 -: 4], RES_W'(STEP_PRIME));

  assign idx_sum = {1'b0, idx} + {1'b0, step[IDX_W-1:0]};
  assign idx_adv = (idx_sum >= (IDX_W+1)'(TABLE_SLOTS)) ?
                   IDX_W'(idx_sum - (IDX_W+1)'(TABLE_SLOTS)) : idx_sum[IDX_W-1:0];

  assign ev_status = slot_status[eval_idx];
  assign ev_empty  = eval_valid && (ev_status == SL_EMPTY);
  assign ev_hit    = eval_valid && (ev_status == SL_OCC) && (mem_rd.key == key_r);
  assign probe_end = ev_empty || ev_hit || (eval_valid && eval_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    issue      = 1'b0;
    fin_go     = 1'b0;
    st_we      = 1'b0;
    st_waddr   = hit_idx;
    st_wdata   = SL_OCC;
    count_next = count;
    res_status = ST_NOT_FOUND;
    res_val    = '0;
    res_slot   = '0;
    mem_req    = '{we: 1'b0, waddr: hit_idx, wkey: key_r, wvalue: val_r,
                   re: 1'b0, raddr: idx};
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        if (nib_cnt == NIB_CW'(NIB_CNT - 1)) begin
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        if (step < RES_W'(TABLE_SLOTS)) begin
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        issue      = issue_cnt < CNT_W'(TABLE_SLOTS);
        mem_req.re = issue;
        if (probe_end) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid || !out_stall) begin
          fin_go     = 1'b1;
          state_next = S_IDLE;
          unique case (func_r)
            FN_INSERT: begin
              if (hit) begin
                res_status = ST_UPDATED;
                res_slot   = hit_idx;
                mem_req.we = 1'b1;
              end else if (have_del || have_empty) begin
                res_status    = ST_INSERTED;
                res_slot      = have_del ? del_idx : empty_idx;
                mem_req.we    = 1'b1;
                mem_req.waddr = res_slot;
                st_we         = 1'b1;
                st_waddr      = res_slot;
                st_wdata      = SL_OCC;
                count_next    = count + CNT_W'(1);
              end else begin
                res_status = ST_FULL;
              end
            end
            FN_LOOKUP: begin
              if (hit) begin
                res_status = ST_FOUND;
                res_val    = hit_val;
                res_slot   = hit_idx;
              end
            end
            FN_REMOVE: begin
              if (hit) begin
                res_status = ST_REMOVED;
                res_slot   = hit_idx;
                st_we      = 1'b1;
                st_wdata   = SL_DEL;
                if (count != '0) begin
                  count_next = count - CNT_W'(1);
                end
              end
            end
            default: begin
              res_status = ST_NOT_FOUND;
            end
          endcase
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eval_valid <= 1'b0;
      out_valid  <= 1'b0;
      count      <= '0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        slot_status[i] <= SL_EMPTY;
      end
    end else begin
      if (state == S_IDLE && in_valid) begin
        eval_valid <= 1'b0;
      end else if (state == S_PROBE) begin
        eval_valid <= issue;
      end
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (st_we) begin
        slot_status[st_waddr] <= st_wdata;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          func_r     <= func;
          key_r      <= key;
          val_r      <= value;
          key_sh     <= PAD_W'(key);
          nib_cnt    <= '0;
          rem_m      <= '0;
          rem_r      <= '0;
          issue_cnt  <= '0;
          hit        <= 1'b0;
          have_del   <= 1'b0;
          have_empty <= 1'b0;
        end
      end
      S_HASH: begin
        key_sh  <= key_sh << 4;
        rem_m   <= rem_m_next;
        rem_r   <= rem_r_next;
        nib_cnt <= nib_cnt + NIB_CW'(1);
        idx     <= rem_m_next[IDX_W-1:0];
        step    <= RES_W'(STEP_PRIME) - rem_r_next;
      end
      S_STEP: begin
        if (step >= RES_W'(TABLE_SLOTS)) begin
          step <= step - RES_W'(TABLE_SLOTS);
        end
      end
      S_PROBE: begin
        if (issue) begin
          idx       <= idx_adv;
          issue_cnt <= issue_cnt + CNT_W'(1);
          eval_idx  <= idx;
          eval_last <= issue_cnt == CNT_W'(TABLE_SLOTS - 1);
        end
        if (eval_valid && ev_status == SL_DEL && !have_del) begin
          have_del <= 1'b1;
          del_idx  <= eval_idx;
        end
        if (ev_empty) begin
          have_empty <= 1'b1;
          empty_idx  <= eval_idx;
        end
        if (ev_hit) begin
          hit     <= 1'b1;
          hit_idx <= eval_idx;
          hit_val <= mem_rd.value;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          out_status <= res_status;
          out_val    <= res_val;
          out_slot   <= res_slot;
          out_count  <= count_next;
        end
      end
      default: begin
      end
    endcase
  end

  assign status     = out_status;
  assign value_out  = 32'(out_val);
  assign slot       = SLOT_W'(out_slot);
  assign live_count = LIVE_W'(out_count);

endmodule

[rtl/core/double_hash_table_core.sv]
// top level of the double hash table: sequencer plus key/value memory
//
// one request channel (func, key, value) and one result channel
// (status, value_out, slot, live_count), both valid/stall handshakes.
// a request is taken only while the core is idle; it then hashes the
// key (reduced one nibble per cycle, mod 11 and mod 7), folds the probe
// step, then reads the key/value memory once per probe, one probe read
// per cycle, for p probes (1 to 11, ended by an empty slot, a key match
// or the last slot), evaluates the last read and ends in a finish cycle
// that writes back and loads the result register. the probe walk runs
// over the single memory read port; the next request is taken only once
// the finish cycle has loaded the result and returned the core to idle.
// the result register holds while out_stall is high; a new request may
// be accepted meanwhile, and its finish cycle waits until the old result
// is taken. reset clears the slot status flags (all empty), the live
// count and both valid flags; the key/value memory is not cleared.
module double_hash_table_core
  import dht_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [FUNC_W-1:0]     func,
  input  logic [KEY_BITS-1:0]   key,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STATUS_W-1:0]   status,
  output logic [31:0]           value_out,
  output logic [SLOT_W-1:0]     slot,
  output logic [LIVE_W-1:0]     live_count
);

  mem_req_t mem_req;
  mem_rd_t  mem_rd;

  dht_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .key        (key),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .value_out  (value_out),
    .slot       (slot),
    .live_count (live_count),
    .mem_req    (mem_req),
    .mem_rd     (mem_rd)
  );

  dht_mem u_mem (
    .clk (clk),
    .req (mem_req),
    .rd  (mem_rd)
  );

endmodule

[rtl/core/dht_checker.sv]
// port-level checks for the double hash table core, bound to the top level
module dht_checker
  import dht_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic [FUNC_W-1:0]     func,
  input logic [KEY_BITS-1:0]   key,
  input logic [VALUE_BITS-1:0] value,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [STATUS_W-1:0]   status,
  input logic [31:0]           value_out,
  input logic [SLOT_W-1:0]     slot,
  input logic [LIVE_W-1:0]     live_count
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(value_out)
      && $stable(slot) && $stable(live_count))
    else $error("stalled result changed");

  // a request keeps the core busy for the following cycle
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while previous one still running");

  // only found returns a value
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_FOUND |-> value_out == '0)
    else $error("value_out nonzero without found");

  // miss and full report slot zero
  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_NOT_FOUND || status == ST_FULL) |-> slot == '0)
    else $error("slot nonzero on miss or full");

  // full table means every slot is live
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> live_count == LIVE_W'(TABLE_SLOTS))
    else $error("table full reported with free slots");

endmodule

bind double_hash_table_core dht_checker u_dht_checker (.*);

[dv/tb_double_hash_table_core.sv]
// testbench for the double hash table core: directed requests checked against typed expectations or a predictor
`timescale 1ns / 1ps

module tb_double_hash_table_core;
  import dht_pkg::*;

  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int RANDOM_PER_PHASE = 584;
  localparam int POOL_SIZE        = 20;

  typedef struct packed {
    status_t               status;
    logic [31:0]           value_out;
    logic [SLOT_W-1:0]     slot;
    logic [LIVE_W-1:0]     live;
  } hash_result_t;

  typedef struct packed {
    logic [FUNC_W-1:0]     op;
    logic [KEY_BITS-1:0]   k;
    logic [VALUE_BITS-1:0] v;
    logic                  typed_in;
    hash_result_t          want;
  } req_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [FUNC_W-1:0]     func = '0;
  logic [KEY_BITS-1:0]   key = '0;
  logic [VALUE_BITS-1:0] value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [STATUS_W-1:0]   status;
  logic [31:0]           value_out;
  logic [SLOT_W-1:0]     slot;
  logic [LIVE_W-1:0]     live_count;

  logic [1:0]            slot_flag [TABLE_SLOTS];
  logic [KEY_BITS-1:0]   slot_key  [TABLE_SLOTS];
  logic [VALUE_BITS-1:0] slot_val  [TABLE_SLOTS];
  int unsigned           live_total;

  hash_result_t          pending_results [$];
  hash_result_t          head_result;
  req_row_t              directed_rows [$];
  logic [KEY_BITS-1:0]   key_pool [POOL_SIZE];

  int tx_idle_pct = 26;
  int rx_idle_pct = 47;
  int errors      = 0;
  int sent_count  = 0;
  int cycle_count = 0;
  int status_seen [6];

  double_hash_table_core u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .key        (key),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .value_out  (value_out),
    .slot       (slot),
    .live_count (live_count)
  );

  always #6 clk = ~clk;

  function automatic hash_result_t hash_table_apply(input logic [FUNC_W-1:0] op,
                                                    input logic [KEY_BITS-1:0] k,
                                                    input logic [VALUE_BITS-1:0] v);
    hash_result_t res;
    int unsigned  idx, stride, hit_idx, del_idx, empty_idx, pos;
    bit           hit, have_del, have_empty;
    hit = 0;
    have_del = 0;
    have_empty = 0;
    hit_idx = 0;
    del_idx = 0;
    empty_idx = 0;
    pos = 0;
    idx = k % TABLE_SLOTS;
    stride = (STEP_PRIME - (k % STEP_PRIME)) % TABLE_SLOTS;
    for (int j = 0; j < TABLE_SLOTS; j++) begin
      if (slot_flag[idx] == SL_EMPTY) begin
        have_empty = 1;
        empty_idx = idx;
        break;
      end
      if (slot_flag[idx] == SL_OCC && slot_key[idx] == k) begin
        hit = 1;
        hit_idx = idx;
        break;
      end
      if (slot_flag[idx] == SL_DEL && !have_del) begin
        have_del = 1;
        del_idx = idx;
      end
      idx = (idx + stride) % TABLE_SLOTS;
    end
    res.status = ST_NOT_FOUND;
    res.value_out = '0;
    if (op == FN_INSERT) begin
      if (hit) begin
        slot_val[hit_idx] = v;
        res.status = ST_UPDATED;
        pos = hit_idx;
      end else if (have_del || have_empty) begin
        pos = have_del ? del_idx : empty_idx;
        slot_key[pos] = k;
        slot_val[pos] = v;
        slot_flag[pos] = SL_OCC;
        live_total++;
        res.status = ST_INSERTED;
      end else begin
        res.status = ST_FULL;
      end
    end else if (op == FN_LOOKUP) begin
      if (hit) begin
        res.status = ST_FOUND;
        res.value_out = slot_val[hit_idx];
        pos = hit_idx;
      end
    end else if (op == FN_REMOVE) begin
      if (hit) begin
        slot_flag[hit_idx] = SL_DEL;
        if (live_total > 0) live_total--;
        res.status = ST_REMOVED;
        pos = hit_idx;
      end
    end
    res.slot = SLOT_W'(pos);
    res.live = LIVE_W'(live_total);
    return res;
  endfunction

  function automatic req_row_t mk_row(input logic [FUNC_W-1:0] op,
                                      input logic [KEY_BITS-1:0] k,
                                      input logic [VALUE_BITS-1:0] v,
                                      input logic typed_in, input status_t st,
                                      input logic [31:0] vo, input int sl, input int lc);
    req_row_t row;
    row.op = op;
    row.k = k;
    row.v = v;
    row.typed_in = typed_in;
    row.want.status = st;
    row.want.value_out = vo;
    row.want.slot = SLOT_W'(sl);
    row.want.live = LIVE_W'(lc);
    return row;
  endfunction

  task automatic send_request(input logic [FUNC_W-1:0] op, input logic [KEY_BITS-1:0] k,
                              input logic [VALUE_BITS-1:0] v, input logic typed_in,
                              input hash_result_t want);
    hash_result_t predicted;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    func <= op;
    key <= k;
    value <= v;
    do @(posedge clk); while (in_stall);
    predicted = hash_table_apply(op, k, v);
    pending_results.push_back(typed_in ? want : predicted);
    sent_count++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (status <= ST_FULL) status_seen[status]++;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: result with no request pending, status %0d", $time, status);
        end else begin
          head_result = pending_results.pop_front();
          if (status !== head_result.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time,
                     head_result.status, status);
          end
          if (value_out !== head_result.value_out) begin
            errors++;
            $display("%0t: value_out expected %h actual %h", $time,
                     head_result.value_out, value_out);
          end
          if (slot !== head_result.slot) begin
            errors++;
            $display("%0t: slot expected %0d actual %0d", $time, head_result.slot, slot);
          end
          if (live_count !== head_result.live) begin
            errors++;
            $display("%0t: live_count expected %0d actual %0d", $time,
                     head_result.live, live_count);
          end
        end
      end
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  initial begin
    int                    pick;
    bit                    drain_bias;
    logic [FUNC_W-1:0]     op;
    logic [KEY_BITS-1:0]   k;
    logic [VALUE_BITS-1:0] v;
    for (int i = 0; i < TABLE_SLOTS; i++) slot_flag[i] = SL_EMPTY;
    for (int i = 0; i < 6; i++) status_seen[i] = 0;
    live_total = 0;
    drain_bias = 0;

    // empty table, then a single key through every operation
    directed_rows.push_back(mk_row(FN_LOOKUP, 32'd0, 32'd0, 1'b1, ST_NOT_FOUND, 0, 0, 0));
    directed_rows.push_back(mk_row(FN_REMOVE, 32'hFFFF_FFFF, 32'd0, 1'b1, ST_NOT_FOUND,
                                   0, 0, 0));
    directed_rows.push_back(mk_row(FN_UNUSED, 32'd5, 32'hFFFF_FFFF, 1'b1, ST_NOT_FOUND,
                                   0, 0, 0));
    directed_rows.push_back(mk_row(FN_INSERT, 32'd0, 32'hFFFF_FFFF, 1'b1, ST_INSERTED,
                                   0, 0, 1));
    directed_rows.push_back(mk_row(FN_LOOKUP, 32'd0, 32'd0, 1'b1, ST_FOUND, 32'hFFFF_FFFF,
                                   0, 1));
    directed_rows.push_back(mk_row(FN_INSERT, 32'd0, 32'd0, 1'b1, ST_UPDATED, 0, 0, 1));
    directed_rows.push_back(mk_row(FN_LOOKUP, 32'd0, 32'hFFFF_FFFF, 1'b1, ST_FOUND, 0, 0, 1));
    directed_rows.push_back(mk_row(FN_REMOVE, 32'd0, 32'd0, 1'b1, ST_REMOVED, 0, 0, 0));
    directed_rows.push_back(mk_row(FN_REMOVE, 32'd0, 32'd0, 1'b1, ST_NOT_FOUND, 0, 0, 0));
    // colliding keys and one other key fill the table, the first one reuses the tombstone
    for (int i = 1; i <= 10; i++)
      directed_rows.push_back(mk_row(FN_INSERT, 32'(11 * i), 32'(i * 32'h1111_0101), 1'b0,
                                     ST_INSERTED, 0, 0, 0));
    directed_rows.push_back(mk_row(FN_INSERT, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 1'b0,
                                   ST_INSERTED, 0, 0, 0));
    // full table: new key, missing key, unused code; then a remove makes room for the new key
    directed_rows.push_back(mk_row(FN_INSERT, 32'h8000_0000, 32'd7, 1'b1, ST_FULL,
                                   0, 0, 11));
    directed_rows.push_back(mk_row(FN_LOOKUP, 32'h8000_0000, 32'd0, 1'b1, ST_NOT_FOUND,
                                   0, 0, 11));
    directed_rows.push_back(mk_row(FN_UNUSED, 32'hFFFF_FFFF, 32'd0, 1'b1, ST_NOT_FOUND,
                                   0, 0, 11));
    directed_rows.push_back(mk_row(FN_REMOVE, 32'd55, 32'd0, 1'b0, ST_REMOVED, 0, 0, 0));
    directed_rows.push_back(mk_row(FN_INSERT, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0,
                                   ST_INSERTED, 0, 0, 0));
    directed_rows.push_back(mk_row(FN_LOOKUP, 32'hFFFF_FFFF, 32'd0, 1'b0, ST_FOUND,
                                   0, 0, 0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_request(directed_rows[i].op, directed_rows[i].k, directed_rows[i].v,
                   directed_rows[i].typed_in, directed_rows[i].want);
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 26 : (ph == 1) ? 47 : 0;
      rx_idle_pct = (ph == 0) ? 47 : (ph == 1) ? 26 : 0;
      for (int i = 0; i < POOL_SIZE; i++) begin
        case (i % 3)
          0: key_pool[i] = $urandom;
          1: key_pool[i] = 32'($urandom_range(300) * 11);
          default: key_pool[i] = 32'($urandom_range(63));
        endcase
      end
      key_pool[0] = 32'hFFFF_FFFF;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (n % 60 == 0) drain_bias = $urandom_range(1);
        pick = $urandom_range(99);
        if (pick < 5) op = FN_UNUSED;
        else if (pick < (drain_bias ? 30 : 55)) op = FN_INSERT;
        else if (pick < (drain_bias ? 55 : 78)) op = FN_LOOKUP;
        else op = FN_REMOVE;
        k = ($urandom_range(99) < 10) ? $urandom : key_pool[$urandom_range(POOL_SIZE - 1)];
        pick = $urandom_range(99);
        v = (pick < 5) ? '0 : (pick < 10) ? '1 : $urandom;
        send_request(op, k, v, 1'b0, '0);
        if ($urandom_range(199) == 0) wait_drained();
      end
      wait_drained();
    end

    repeat (25) @(posedge clk);
    $display("ran %0d requests: directed table plus random mixes under three idle profiles",
             sent_count);
    $display("seen %0d inserted, %0d updated, %0d found, %0d removed, %0d missed, %0d full",
             status_seen[ST_INSERTED], status_seen[ST_UPDATED], status_seen[ST_FOUND],
             status_seen[ST_REMOVED], status_seen[ST_NOT_FOUND], status_seen[ST_FULL]);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
